// ----- sv/pom_pkg.sv -----
// shared types and constants of the poisson occupancy multiplicity block
// no dependencies; used by pom_div and poisson_occupancy_multiplicity
package pom_pkg;

   // transaction codes of the request channel
   localparam logic [1:0] REQ_OBSERVE = 2'd0;
   localparam logic [1:0] REQ_QUERY   = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;

   // register map of the csr port
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_RING_INNER      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ETA_LUMPING     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHI_LUMPING     = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RUNNING_AVERAGE = 4'd3;

   localparam logic [9:0] ETA_LUMP_RESET = 10'd32;
   localparam logic [5:0] PHI_LUMP_RESET = 6'd4;

   // ring geometry
   localparam logic [9:0] STRIPS_INNER  = 10'd512;
   localparam logic [9:0] STRIPS_OUTER  = 10'd256;
   localparam logic [5:0] SECTORS_INNER = 6'd20;
   localparam logic [5:0] SECTORS_OUTER = 6'd40;

   // cell and region index width (511*40+39 and 511*79+39 fit)
   localparam int unsigned IDX_W = 17;

   // ln2 in Q28 and the stand-in empty count of 0.001 (applied as ln(1000))
   localparam logic [27:0] LN2_Q28     = 28'd186065279;
   localparam logic [31:0] LN_THOUSAND = 32'd1000;
   localparam logic [4:0]  LN_LAST_ITER   = 5'd29;
   localparam logic [4:0]  SQRT_LAST_ITER = 5'd23;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [8:0]  strip;
      logic [5:0]  sector;
      logic        hit;
      logic [15:0] weight;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] error;
   } rsp_payload_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
      logic [6:0]  steps;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_COLS,
      ST_DIV_ETA,
      ST_DIV_PHI,
      ST_INDEX,
      ST_READ,
      ST_EVAL,
      ST_LN_NORM,
      ST_LN_SQ,
      ST_LN_MUL_HI,
      ST_LN_MUL_LO,
      ST_LN_DONE,
      ST_MUL_NT,
      ST_DIV_K,
      ST_PROD_LO,
      ST_PROD_HI,
      ST_SQRT,
      ST_DONE
   } state_type;

endpackage

// ----- sv/poisson_occupancy_multiplicity.sv -----
// top level of the poisson zero-count occupancy multiplicity estimator
// depends on pom_pkg and pom_div
//
// usage
//   req channel (valid/ready): one transaction per observation, query or clear.
//   rsp channel (valid/ready): one transaction per query with value and error.
//   csr channel (valid/ready, always ready): register writes, idle block only.
// timing
//   one request at a time; req_ready is high only while the sequencer is idle.
//   observation: three region divisions on the shared bit-serial divider
//     (7 + 9 + 6 steps), then memory read and write.
//   query: the same indexing, then two logarithms on the shared 32x32 multiplier
//     (normalize, 30 squarings, two ln2 products), a 64-step division unless
//     the region was never empty, two products and 24 square-root steps; a
//     query that answers zero goes straight to the square root.
//   clear: a sweep over the hit memory, and over the region memories unless running average is on.
// reset
//   registers take their defaults and the same sweep zeroes all three
//   memories; req_ready stays low during any sweep.
// stall
//   the result sits in an output register; a new request is accepted while it
//   waits, and a following query holds in its last state until rsp is free.
module poisson_occupancy_multiplicity #(
   parameter int unsigned CELL_COUNT  = 10240,
   parameter int unsigned COUNT_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  pom_pkg::req_payload_type              req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pom_pkg::rsp_payload_type              rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pom_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pom_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int unsigned AW    = $clog2(CELL_COUNT);
   localparam int unsigned SUM_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);
   localparam logic [pom_pkg::IDX_W-1:0] IDX_LIMIT = pom_pkg::IDX_W'(CELL_COUNT);

   // saturating counter add
   function automatic logic [COUNT_WIDTH-1:0] sat_add(
      input logic [COUNT_WIDTH-1:0] a,
      input logic [15:0]            b
   );
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(b);
      sat_add = (s > SUM_W'(CNT_MAX)) ? CNT_MAX : s[COUNT_WIDTH-1:0];
   endfunction

   // configuration registers
   logic       ring_inner_ff;
   logic [9:0] eta_lump_ff;
   logic [5:0] phi_lump_ff;
   logic       run_avg_ff;

   // sequencer
   pom_pkg::state_type state_ff, state_in;
   logic div_go_ff, div_go_in;

   // request and clear control
   pom_pkg::req_payload_type req_ff;
   logic          clear_regions_ff;
   logic [AW-1:0] clear_ptr_ff;

   // indexing
   logic [6:0] cols_ff;
   logic [8:0] qe_ff;
   logic [5:0] qp_ff;
   logic [pom_pkg::IDX_W-1:0] cell_ff, region_ff;
   logic ok_ff;

   // memories and read data
   logic [COUNT_WIDTH-1:0] hit_mem [CELL_COUNT];
   logic [COUNT_WIDTH-1:0] tot_mem [CELL_COUNT];
   logic [COUNT_WIDTH-1:0] emp_mem [CELL_COUNT];
   logic [COUNT_WIDTH-1:0] h_ff, t_ff, e_ff;

   // logarithm unit state
   logic [31:0] ln_m_ff;
   logic [4:0]  ln_p_ff;
   logic [29:0] ln_frac_ff;
   logic [4:0]  ln_cnt_ff;
   logic        ln_pass_ff;
   logic [62:0] ln_acc_ff;
   logic [34:0] ln_t_ff, ln_e_ff;

   // correction and product
   logic [22:0] m16_ff;
   logic [63:0] nt_ff;
   logic [63:0] k_ff;
   logic [63:0] plo_ff;
   logic [31:0] value_ff;

   // square root
   logic [47:0] sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [4:0]  sq_cnt_ff;

   // result register
   logic                      rsp_valid_ff;
   pom_pkg::rsp_payload_type  rsp_data_ff;
   logic                      rsp_load;

   // shared multiplier and divider
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_prod;
   pom_pkg::div_req_type div_req;
   pom_pkg::div_rsp_type div_rsp;

   // derived geometry
   logic [9:0] n_strip;
   logic [5:0] n_sec, el_lo, pl_lo;
   logic [9:0] el;
   logic [6:0] cols_num;
   assign n_strip  = ring_inner_ff ? pom_pkg::STRIPS_INNER : pom_pkg::STRIPS_OUTER;
   assign n_sec    = ring_inner_ff ? pom_pkg::SECTORS_INNER : pom_pkg::SECTORS_OUTER;
   assign el       = (eta_lump_ff == 10'd0) ? 10'd1 : eta_lump_ff;
   assign pl_lo    = (phi_lump_ff == 6'd0) ? 6'd1 : phi_lump_ff;
   assign el_lo    = pl_lo;
   assign cols_num = {1'b0, n_sec} + {1'b0, el_lo} - 7'd1;

   // query operands
   logic [31:0] h32, t32, e32;
   logic        e_zero, q_zero, is_obs;
   assign h32    = 32'(h_ff);
   assign t32    = 32'(t_ff);
   assign e32    = 32'(e_ff);
   assign e_zero = (e_ff == '0);
   assign q_zero = !ok_ff || (t_ff == '0) || (e_ff >= t_ff) || (h_ff == '0);
   assign is_obs = (req_ff.req_type == pom_pkg::REQ_OBSERVE);

   // logarithm step: square, renormalize, shift one fraction bit in
   logic [34:0] lg;
   logic [32:0] ln_sq;
   logic [62:0] ln_sum;
   assign lg     = {ln_p_ff, ln_frac_ff};
   assign ln_sq  = mul_prod[63:31];
   assign ln_sum = ln_acc_ff + mul_prod[62:0];

   // mean and rounding to Q16
   logic [36:0] m30, m30_rnd;
   assign m30     = e_zero ? ({2'b0, ln_t_ff} + {2'b0, ln_e_ff})
                           : ({2'b0, ln_t_ff} - {2'b0, ln_e_ff});
   assign m30_rnd = m30 + 37'd8192;

   // final product and saturation at 2^40
   logic [64:0] acc_hi;
   logic [31:0] v_calc;
   assign acc_hi = {1'b0, plo_ff[63:32]} + {1'b0, mul_prod};
   assign v_calc = (|acc_hi[64:8]) ? 32'hFFFF_FFFF : {acc_hi[7:0], plo_ff[31:8]};

   // square-root step
   logic [48:0] sq_trial;
   logic        sq_fits;
   assign sq_trial = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};
   assign sq_fits  = {1'b0, sq_v_ff} >= sq_trial;

   // index arithmetic
   logic [pom_pkg::IDX_W-1:0] cell_calc, region_calc;
   assign cell_calc   = pom_pkg::IDX_W'(req_ff.strip) * pom_pkg::IDX_W'(n_sec)
                        + pom_pkg::IDX_W'(req_ff.sector);
   assign region_calc = pom_pkg::IDX_W'(qe_ff) * pom_pkg::IDX_W'(cols_ff)
                        + pom_pkg::IDX_W'(qp_ff);

   // shared 32x32 multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         pom_pkg::ST_LN_SQ: begin
            mul_a = ln_m_ff;
            mul_b = ln_m_ff;
         end
         pom_pkg::ST_LN_MUL_HI: begin
            mul_a = 32'(lg[34:18]);
            mul_b = 32'(pom_pkg::LN2_Q28);
         end
         pom_pkg::ST_LN_MUL_LO: begin
            mul_a = 32'(lg[17:0]);
            mul_b = 32'(pom_pkg::LN2_Q28);
         end
         pom_pkg::ST_MUL_NT: begin
            mul_a = 32'(m16_ff);
            mul_b = t32;
         end
         pom_pkg::ST_PROD_LO: begin
            mul_a = h32;
            mul_b = k_ff[31:0];
         end
         pom_pkg::ST_PROD_HI: begin
            mul_a = h32;
            mul_b = k_ff[63:32];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_prod = 64'(mul_a) * 64'(mul_b);

   pom_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pom_pkg::ST_CLEAR: begin
            if (clear_ptr_ff == LAST_ADDR) state_in = pom_pkg::ST_IDLE;
         end
         pom_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_data.req_type)
                  pom_pkg::REQ_CLEAR:   state_in = pom_pkg::ST_CLEAR;
                  pom_pkg::REQ_OBSERVE,
                  pom_pkg::REQ_QUERY:   state_in = pom_pkg::ST_DIV_COLS;
                  default:              state_in = pom_pkg::ST_IDLE;
               endcase
            end
         end
         pom_pkg::ST_DIV_COLS: if (div_rsp.done) state_in = pom_pkg::ST_DIV_ETA;
         pom_pkg::ST_DIV_ETA:  if (div_rsp.done) state_in = pom_pkg::ST_DIV_PHI;
         pom_pkg::ST_DIV_PHI:  if (div_rsp.done) state_in = pom_pkg::ST_INDEX;
         pom_pkg::ST_INDEX:    state_in = pom_pkg::ST_READ;
         pom_pkg::ST_READ:     state_in = pom_pkg::ST_EVAL;
         pom_pkg::ST_EVAL: begin
            if (is_obs)      state_in = pom_pkg::ST_IDLE;
            else if (q_zero) state_in = pom_pkg::ST_SQRT;
            else             state_in = pom_pkg::ST_LN_NORM;
         end
         pom_pkg::ST_LN_NORM: if (ln_m_ff[31]) state_in = pom_pkg::ST_LN_SQ;
         pom_pkg::ST_LN_SQ: begin
            if (ln_cnt_ff == pom_pkg::LN_LAST_ITER) state_in = pom_pkg::ST_LN_MUL_HI;
         end
         pom_pkg::ST_LN_MUL_HI: state_in = pom_pkg::ST_LN_MUL_LO;
         pom_pkg::ST_LN_MUL_LO: begin
            state_in = ln_pass_ff ? pom_pkg::ST_LN_DONE : pom_pkg::ST_LN_NORM;
         end
         pom_pkg::ST_LN_DONE: begin
            state_in = e_zero ? pom_pkg::ST_PROD_LO : pom_pkg::ST_MUL_NT;
         end
         pom_pkg::ST_MUL_NT:  state_in = pom_pkg::ST_DIV_K;
         pom_pkg::ST_DIV_K:   if (div_rsp.done) state_in = pom_pkg::ST_PROD_LO;
         pom_pkg::ST_PROD_LO: state_in = pom_pkg::ST_PROD_HI;
         pom_pkg::ST_PROD_HI: state_in = pom_pkg::ST_SQRT;
         pom_pkg::ST_SQRT: begin
            if (sq_cnt_ff == pom_pkg::SQRT_LAST_ITER) state_in = pom_pkg::ST_DONE;
         end
         pom_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = pom_pkg::ST_IDLE;
         end
         default: state_in = pom_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = (state_ff == pom_pkg::ST_IDLE);
      rsp_load  = (state_ff == pom_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
      div_go_in = (state_in != state_ff) &&
                  ((state_in == pom_pkg::ST_DIV_COLS) || (state_in == pom_pkg::ST_DIV_ETA) ||
                   (state_in == pom_pkg::ST_DIV_PHI) || (state_in == pom_pkg::ST_DIV_K));
      div_req.start    = div_go_ff;
      div_req.dividend = '0;
      div_req.divisor  = 32'd1;
      div_req.steps    = 7'd1;
      case (state_ff)
         pom_pkg::ST_DIV_COLS: begin
            // regions per strip band, rounded up
            div_req.dividend = {cols_num, 57'd0};
            div_req.divisor  = 32'(pl_lo);
            div_req.steps    = 7'd7;
         end
         pom_pkg::ST_DIV_ETA: begin
            div_req.dividend = {req_ff.strip, 55'd0};
            div_req.divisor  = 32'(el);
            div_req.steps    = 7'd9;
         end
         pom_pkg::ST_DIV_PHI: begin
            div_req.dividend = {req_ff.sector, 58'd0};
            div_req.divisor  = 32'(pl_lo);
            div_req.steps    = 7'd6;
         end
         pom_pkg::ST_DIV_K: begin
            // occupancy correction t / (t - e)
            div_req.dividend = nt_ff;
            div_req.divisor  = t32 - e32;
            div_req.steps    = 7'd64;
         end
         default: begin
            div_req.dividend = '0;
            div_req.divisor  = 32'd1;
            div_req.steps    = 7'd1;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= pom_pkg::ST_CLEAR;
         div_go_ff        <= 1'b0;
         clear_ptr_ff     <= '0;
         clear_regions_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
         ring_inner_ff    <= 1'b1;
         eta_lump_ff      <= pom_pkg::ETA_LUMP_RESET;
         phi_lump_ff      <= pom_pkg::PHI_LUMP_RESET;
         run_avg_ff       <= 1'b0;
      end else begin
         state_ff  <= state_in;
         div_go_ff <= div_go_in;

         if (state_ff == pom_pkg::ST_CLEAR) begin
            clear_ptr_ff <= clear_ptr_ff + AW'(1);
         end else if (req_valid && req_ready &&
                      (req_data.req_type == pom_pkg::REQ_CLEAR)) begin
            clear_ptr_ff     <= '0;
            clear_regions_ff <= !run_avg_ff;
         end

         if (rsp_load)                 rsp_valid_ff <= 1'b1;
         else if (rsp_ready)           rsp_valid_ff <= 1'b0;

         if (csr_valid) begin
            case (csr_index)
               pom_pkg::CSR_RING_INNER:      ring_inner_ff <= csr_data[0];
               pom_pkg::CSR_ETA_LUMPING:     eta_lump_ff   <= csr_data[9:0];
               pom_pkg::CSR_PHI_LUMPING:     phi_lump_ff   <= csr_data[5:0];
               pom_pkg::CSR_RUNNING_AVERAGE: run_avg_ff    <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   assign csr_ready = 1'b1;

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      if (rsp_load) begin
         rsp_data_ff.value <= value_ff;
         rsp_data_ff.error <= sq_res_ff[31:0];
      end
      case (state_ff)
         pom_pkg::ST_DIV_COLS: if (div_rsp.done) cols_ff <= div_rsp.quotient[6:0];
         pom_pkg::ST_DIV_ETA:  if (div_rsp.done) qe_ff   <= div_rsp.quotient[8:0];
         pom_pkg::ST_DIV_PHI:  if (div_rsp.done) qp_ff   <= div_rsp.quotient[5:0];
         pom_pkg::ST_INDEX: begin
            cell_ff   <= cell_calc;
            region_ff <= region_calc;
            ok_ff     <= ({1'b0, req_ff.strip} < n_strip) && (req_ff.sector < n_sec) &&
                         (cell_calc < IDX_LIMIT) && (region_calc < IDX_LIMIT);
         end
         pom_pkg::ST_EVAL: begin
            // first logarithm operand is the region total
            ln_m_ff    <= t32;
            ln_p_ff    <= 5'd31;
            ln_pass_ff <= 1'b0;
            value_ff   <= '0;
            sq_v_ff    <= '0;
            sq_res_ff  <= '0;
            sq_bit_ff  <= 48'h4000_0000_0000;
            sq_cnt_ff  <= '0;
         end
         pom_pkg::ST_LN_NORM: begin
            if (ln_m_ff[31]) begin
               ln_cnt_ff  <= '0;
               ln_frac_ff <= '0;
            end else begin
               ln_m_ff <= {ln_m_ff[30:0], 1'b0};
               ln_p_ff <= ln_p_ff - 5'd1;
            end
         end
         pom_pkg::ST_LN_SQ: begin
            ln_m_ff    <= ln_sq[32] ? ln_sq[32:1] : ln_sq[31:0];
            ln_frac_ff <= {ln_frac_ff[28:0], ln_sq[32]};
            ln_cnt_ff  <= ln_cnt_ff + 5'd1;
         end
         pom_pkg::ST_LN_MUL_HI: ln_acc_ff <= {mul_prod[44:0], 18'd0};
         pom_pkg::ST_LN_MUL_LO: begin
            if (!ln_pass_ff) begin
               ln_t_ff    <= ln_sum[62:28];
               // second operand: empty count, or 1000 for a never-empty region
               ln_m_ff    <= e_zero ? pom_pkg::LN_THOUSAND : e32;
               ln_p_ff    <= 5'd31;
               ln_pass_ff <= 1'b1;
            end else begin
               ln_e_ff <= ln_sum[62:28];
            end
         end
         pom_pkg::ST_LN_DONE: begin
            m16_ff <= m30_rnd[36:14];
            k_ff   <= 64'(m30_rnd[36:14]);
         end
         pom_pkg::ST_MUL_NT:  nt_ff <= mul_prod;
         pom_pkg::ST_DIV_K:   if (div_rsp.done) k_ff <= div_rsp.quotient;
         pom_pkg::ST_PROD_LO: plo_ff <= mul_prod;
         pom_pkg::ST_PROD_HI: begin
            value_ff <= v_calc;
            sq_v_ff  <= {v_calc, 16'd0};
         end
         pom_pkg::ST_SQRT: begin
            if (sq_fits) begin
               sq_v_ff   <= sq_v_ff - sq_trial[47:0];
               sq_res_ff <= {1'b0, sq_res_ff[47:1]} + sq_bit_ff;
            end else begin
               sq_res_ff <= {1'b0, sq_res_ff[47:1]};
            end
            sq_bit_ff <= {2'b0, sq_bit_ff[47:2]};
            sq_cnt_ff <= sq_cnt_ff + 5'd1;
         end
         default: ;
      endcase
   end

   // count memories: one write and one registered read each
   logic [AW-1:0] cell_addr, region_addr;
   logic obs_write;
   assign cell_addr   = cell_ff[AW-1:0];
   assign region_addr = region_ff[AW-1:0];
   assign obs_write   = (state_ff == pom_pkg::ST_EVAL) && is_obs && ok_ff;

   always_ff @(posedge clock) begin
      if (state_ff == pom_pkg::ST_CLEAR) begin
         hit_mem[clear_ptr_ff] <= '0;
      end else if (obs_write && req_ff.hit) begin
         hit_mem[cell_addr] <= sat_add(h_ff, req_ff.weight);
      end
      if (state_ff == pom_pkg::ST_READ) h_ff <= hit_mem[cell_addr];
   end

   always_ff @(posedge clock) begin
      if ((state_ff == pom_pkg::ST_CLEAR) && clear_regions_ff) begin
         tot_mem[clear_ptr_ff] <= '0;
      end else if (obs_write) begin
         tot_mem[region_addr] <= sat_add(t_ff, 16'd1);
      end
      if (state_ff == pom_pkg::ST_READ) t_ff <= tot_mem[region_addr];
   end

   always_ff @(posedge clock) begin
      if ((state_ff == pom_pkg::ST_CLEAR) && clear_regions_ff) begin
         emp_mem[clear_ptr_ff] <= '0;
      end else if (obs_write && !req_ff.hit) begin
         emp_mem[region_addr] <= sat_add(e_ff, 16'd1);
      end
      if (state_ff == pom_pkg::ST_READ) e_ff <= emp_mem[region_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_ln_normalized: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pom_pkg::ST_LN_SQ) |-> ln_m_ff[31])
      else $error("logarithm squaring on an unnormalized mantissa");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == pom_pkg::ST_DONE))
      else $error("result raised outside the final query state");

endmodule

// ----- sv/pom_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on pom_pkg (div_req_type, div_rsp_type)
module pom_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pom_pkg::div_req_type  div_req,
   output pom_pkg::div_rsp_type  div_rsp
);

   logic        busy_ff;
   logic        done_ff;
   logic [6:0]  count_ff;
   logic [63:0] dvd_ff;
   logic [31:0] rem_ff;
   logic [31:0] dsr_ff;
   logic [63:0] quo_ff;

   logic [32:0] rem_shift;
   logic        fits;
   logic [32:0] rem_next;

   // dividend is left aligned, msb first
   assign rem_shift = {rem_ff, dvd_ff[63]};
   assign fits      = rem_shift >= {1'b0, dsr_ff};
   assign rem_next  = fits ? (rem_shift - {1'b0, dsr_ff}) : rem_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= div_req.steps;
         end else if (busy_ff) begin
            count_ff <= count_ff - 7'd1;
            if (count_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[62:0], 1'b0};
         rem_ff <= rem_next[31:0];
         quo_ff <= {quo_ff[62:0], fits};
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- tb/sv/tb.sv -----
// testbench for poisson_occupancy_multiplicity: directed and random request traffic
// depends on pom_pkg and the block's rtl; the expected results come from a local predictor
module tb;

   localparam int unsigned CELLS    = 10240;
   localparam int unsigned CNT_MAX  = (1 << 24) - 1;
   localparam logic [1:0]  REQ_NONE = 2'd3;      // unused request code, block drops it
   localparam int unsigned SETTLE   = CELLS + 400; // a clear sweep plus slack

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pom_pkg::req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pom_pkg::rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pom_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pom_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   poisson_occupancy_multiplicity u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the registers and the three count memories
   logic       ring_sel = 1'b1;
   logic [9:0] eta_lump = pom_pkg::ETA_LUMP_RESET;
   logic [5:0] phi_lump = pom_pkg::PHI_LUMP_RESET;
   logic       keep_regions = 1'b0;
   int unsigned cell_hits [CELLS];
   int unsigned reg_total [CELLS];
   int unsigned reg_empty [CELLS];

   pom_pkg::req_payload_type send_queue [$];   // requests waiting for the driver
   pom_pkg::rsp_payload_type mult_due [$];     // predicted query answers, oldest first
   int   failures = 0;
   int   idle_pct = 25;
   logic long_stall_go = 1'b0;

   function automatic int unsigned sat_inc(int unsigned a, int unsigned b);
      longint unsigned s;
      s = longint'(a) + b;
      return (s > CNT_MAX) ? CNT_MAX : int'(s);
   endfunction

   // natural log in Q30: log2 by repeated squaring, then times ln2
   function automatic longint unsigned ln_fix(int unsigned x);
      int p;
      longint unsigned m, frac;
      frac = 0;
      if (x == 0) return 0;
      p = 31;
      while (x[p] == 1'b0) p--;
      m = longint'(x) << (31 - p);
      for (int i = 0; i < 30; i++) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            frac |= 64'd1 << (29 - i);
         end
      end
      return (((longint'(p) << 30) | frac) * pom_pkg::LN2_Q28) >> 28;
   endfunction

   function automatic int unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return int'(res);
   endfunction

   // corrected multiplicity from hit sum, region total and region empty count
   function automatic int unsigned occupancy_mult(int unsigned h, int unsigned t,
                                                   int unsigned e);
      longint unsigned m30, m16, k, lim;
      if (t == 0 || e >= t || h == 0) return 0;
      if (e == 0) m30 = ln_fix(t) + ln_fix(1000);
      else m30 = ln_fix(t) - ln_fix(e);
      m16 = (m30 + (64'd1 << 13)) >> 14;
      // never-empty region: correction factor is one
      if (e == 0) k = m16;
      else k = (m16 * t) / longint'(t - e);
      if (k == 0) return 0;
      lim = ((64'd1 << 40) - 1) / k;
      if (longint'(h) > lim) return 32'hFFFF_FFFF;
      return int'((longint'(h) * k) >> 8);
   endfunction

   // applies one accepted request to the predictor state
   task automatic track_request(pom_pkg::req_payload_type r);
      int unsigned nstrip, nsec, el, pl, cols, cell_idx, region, v;
      logic ok;
      pom_pkg::rsp_payload_type exp_rsp;
      nstrip = ring_sel ? 512 : 256;
      nsec = ring_sel ? 20 : 40;
      el = (eta_lump == 0) ? 1 : eta_lump;
      pl = (phi_lump == 0) ? 1 : phi_lump;
      cols = (nsec + pl - 1) / pl;
      cell_idx = r.strip * nsec + r.sector;
      region = (r.strip / el) * cols + r.sector / pl;
      ok = r.strip < nstrip && r.sector < nsec && cell_idx < CELLS && region < CELLS;
      case (r.req_type)
         pom_pkg::REQ_CLEAR: begin
            foreach (cell_hits[i]) cell_hits[i] = 0;
            if (!keep_regions) begin
               foreach (reg_total[i]) begin
                  reg_total[i] = 0;
                  reg_empty[i] = 0;
               end
            end
         end
         pom_pkg::REQ_OBSERVE: begin
            if (ok) begin
               reg_total[region] = sat_inc(reg_total[region], 1);
               if (r.hit) cell_hits[cell_idx] = sat_inc(cell_hits[cell_idx], r.weight);
               else reg_empty[region] = sat_inc(reg_empty[region], 1);
            end
         end
         pom_pkg::REQ_QUERY: begin
            v = ok ? occupancy_mult(cell_hits[cell_idx], reg_total[region],
                                    reg_empty[region]) : 0;
            exp_rsp.value = v;
            exp_rsp.error = int_sqrt(longint'(v) << 16);
            mult_due.push_back(exp_rsp);
         end
         default: ;
      endcase
   endtask

   // driver: offers the next queued transaction, holds it until accepted
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) track_request(req_data);
         if (!req_valid || req_ready) begin
            if (send_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_data <= send_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result transaction, plus random and long back-pressure
   int stall_count = 0;
   always @(posedge clock) begin : rsp_monitor
      pom_pkg::rsp_payload_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (mult_due.size() == 0) begin
               $error("unexpected result value %0h error %0h", rsp_data.value,
                      rsp_data.error);
               failures++;
            end else begin
               exp_rsp = mult_due.pop_front();
               if (rsp_data.value !== exp_rsp.value) begin
                  $error("value: expected %0h got %0h", exp_rsp.value, rsp_data.value);
                  failures++;
               end
               if (rsp_data.error !== exp_rsp.error) begin
                  $error("error: expected %0h got %0h", exp_rsp.error, rsp_data.error);
                  failures++;
               end
            end
         end
         // one long hold-off so the block backs up into the request side
         if (long_stall_go && stall_count < 3000) begin
            stall_count++;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   function automatic pom_pkg::req_payload_type mk(logic [1:0] kind, int unsigned s,
                                                   int unsigned c, logic h,
                                                   int unsigned w);
      pom_pkg::req_payload_type r;
      r.req_type = kind;
      r.strip = 9'(s);
      r.sector = 6'(c);
      r.hit = h;
      r.weight = 16'(w);
      return r;
   endfunction

   task automatic csr_write(logic [pom_pkg::CSR_INDEX_W-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= pom_pkg::CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         pom_pkg::CSR_RING_INNER:      ring_sel = val[0];
         pom_pkg::CSR_ETA_LUMPING:     eta_lump = val[9:0];
         pom_pkg::CSR_PHI_LUMPING:     phi_lump = val[5:0];
         pom_pkg::CSR_RUNNING_AVERAGE: keep_regions = val[0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(int unsigned ring, int unsigned el, int unsigned pl,
                               int unsigned avg);
      csr_write(pom_pkg::CSR_RING_INNER, ring);
      csr_write(pom_pkg::CSR_ETA_LUMPING, el);
      csr_write(pom_pkg::CSR_PHI_LUMPING, pl);
      csr_write(pom_pkg::CSR_RUNNING_AVERAGE, avg);
   endtask

   // waits until all queued transactions are taken and every answer is back
   // (sampled between edges so the driver's updates have settled)
   task automatic drain;
      while (send_queue.size() > 0 || req_valid || mult_due.size() > 0) @(negedge clock);
   endtask

   // drain, then let a trailing observation or clear sweep finish
   task automatic go_idle;
      drain();
      repeat (SETTLE) @(posedge clock);
   endtask

   // random traffic concentrated on a cluster of cells sharing regions
   task automatic random_traffic(int n);
      int unsigned nstrip, nsec, bs, bc, s, c, r, w;
      nstrip = ring_sel ? 512 : 256;
      nsec = ring_sel ? 20 : 40;
      bs = $urandom_range(nstrip - 4);
      bc = $urandom_range(nsec - 4);
      for (int i = 0; i < n; i++) begin
         s = bs + $urandom_range(3);
         c = bc + $urandom_range(3);
         r = $urandom_range(99);
         w = $urandom_range(9) == 0 ? 16'hFFFF : $urandom_range(16'hFFFF);
         if (r < 55)
            send_queue.push_back(mk(pom_pkg::REQ_OBSERVE, s, c, 1'($urandom_range(1)), w));
         else if (r < 80)
            send_queue.push_back(mk(pom_pkg::REQ_QUERY, s, c, 1'($urandom_range(1)), w));
         else if (r < 86)
            send_queue.push_back(mk(pom_pkg::REQ_QUERY, $urandom_range(nstrip - 1),
                                    $urandom_range(nsec - 1), 1'b0, w));
         else if (r < 88)
            send_queue.push_back(mk(pom_pkg::REQ_CLEAR, s, c, 1'b0, w));
         else
            // noise: any code, any cell, including outside the ring
            send_queue.push_back(mk(2'($urandom_range(3)), $urandom_range(511),
                                    $urandom_range(63), 1'($urandom_range(1)),
                                    $urandom_range(16'hFFFF)));
      end
   endtask

   initial begin : timeout
      #20000000;
      $display("tb: errors");
      $finish;
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part with the reset geometry: 512 x 20, lumping 32 x 4
      send_queue.push_back(mk(pom_pkg::REQ_QUERY, 10, 5, 1'b0, 0));   // no observations
      send_queue.push_back(mk(pom_pkg::REQ_OBSERVE, 10, 5, 1'b1, 16'hFFFF));
      send_queue.push_back(mk(pom_pkg::REQ_OBSERVE, 10, 5, 1'b1, 0));
      send_queue.push_back(mk(pom_pkg::REQ_QUERY, 10, 5, 1'b0, 0));   // never-empty region
      send_queue.push_back(mk(pom_pkg::REQ_OBSERVE, 11, 6, 1'b0, 16'h1234));
      send_queue.push_back(mk(pom_pkg::REQ_QUERY, 10, 5, 1'b0, 0));   // partly empty
      send_queue.push_back(mk(pom_pkg::REQ_OBSERVE, 200, 0, 1'b0, 0));
      send_queue.push_back(mk(pom_pkg::REQ_OBSERVE, 200, 1, 1'b0, 0));
      send_queue.push_back(mk(pom_pkg::REQ_QUERY, 200, 0, 1'b0, 0));  // always-empty region
      send_queue.push_back(mk(pom_pkg::REQ_OBSERVE, 511, 19, 1'b1, 16'h0100));
      send_queue.push_back(mk(pom_pkg::REQ_QUERY, 511, 19, 1'b0, 0)); // far corner
      send_queue.push_back(mk(pom_pkg::REQ_OBSERVE, 511, 39, 1'b1, 16'hFFFF)); // sector outside
      send_queue.push_back(mk(pom_pkg::REQ_QUERY, 511, 63, 1'b1, 16'hFFFF));
      send_queue.push_back(mk(REQ_NONE, 10, 5, 1'b1, 16'hFFFF));
      send_queue.push_back(mk(pom_pkg::REQ_QUERY, 0, 0, 1'b0, 0));
      send_queue.push_back(mk(pom_pkg::REQ_CLEAR, 0, 0, 1'b0, 0));
      send_queue.push_back(mk(pom_pkg::REQ_QUERY, 10, 5, 1'b0, 0));   // after a clear
      go_idle();

      // outer ring, one region over the whole ring, counts kept across clears
      set_geometry(0, 256, 40, 1);
      random_traffic(100);
      go_idle();

      // finest lumping on the inner ring, with a saturating result
      set_geometry(1, 1, 1, 0);
      for (int i = 0; i < 40; i++)
         send_queue.push_back(mk(pom_pkg::REQ_OBSERVE, 300, 7, 1'b1, 16'hFFFF));
      send_queue.push_back(mk(pom_pkg::REQ_QUERY, 300, 7, 1'b0, 0));
      random_traffic(60);
      go_idle();

      // zero lumping with no idling, then oversized eta and phi lumping
      set_geometry(0, 0, 0, 0);
      idle_pct = 0;
      random_traffic(80);
      drain();
      idle_pct = 25;
      go_idle();
      set_geometry(1, 1023, 63, 1);
      random_traffic(60);
      go_idle();

      // lumping that leaves partial regions, then back-pressure tests
      set_geometry(1, 512, 3, 0);
      random_traffic(100);
      drain();   // sender pause until every answer is back
      long_stall_go <= 1'b1;
      for (int i = 0; i < 20; i++)
         send_queue.push_back(mk(pom_pkg::REQ_QUERY, $urandom_range(511),
                                 $urandom_range(19), 1'b0, 0));
      random_traffic(60);
      go_idle();

      // back to the reset values
      set_geometry(1, 32, 4, 0);
      random_traffic(120);
      go_idle();

      if (failures == 0 && mult_due.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
